/* sv/pmd_pkg.sv */
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants of the position motor drive controller.
// ----------------------------------------------------------------------------
package pmd_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_DEAD_BAND  = 3'd3,
    REG_SUM_LIMIT  = 3'd4,
    REG_DUTY_MAX   = 3'd5,
    REG_DUTY_MIN   = 3'd6,
    REG_ENABLE     = 3'd7
  } pmd_reg_t;

  // item kinds on the input channel
  localparam logic MODE_SET_TARGET = 1'b0;
  localparam logic MODE_TICK       = 1'b1;

  localparam int GAIN_W    = 16;
  localparam int BAND_W    = 16;
  localparam int LIMIT_W   = 31;
  localparam int ESUM_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // products saturate at +-2^60, operands beyond +-2^45 saturate
  localparam int PROD_W   = 62;
  localparam int ACC_W    = 64;
  localparam int SAT_X_W  = 46;
  localparam int FRAC_W   = 8;
  localparam logic signed [PROD_W-1:0] PROD_LIM  = 62'sh1000_0000_0000_0000;
  localparam logic signed [63:0]       SAT_BOUND = 64'sh0000_2000_0000_0000;

  // control that travels with an item down the pipeline
  typedef struct packed {
    logic valid;
    logic brake;
  } pmd_ctl_t;

endpackage

/* sv/pid_position_motor_drive.sv */
// ----------------------------------------------------------------------------
// pid_position_motor_drive
// PID position controller with deadband driving a two-channel motor bridge.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled. The input register loads at the
// accepting edge and a tick's duty result is offered on out_tvalid after the
// error/state stage, the multiplier register and the result register.
// Set-target items and ticks while disabled leave the input register
// in one cycle and give no result. The loop state is updated in the error stage,
// so consecutive ticks need no gap. A result that waits on out_tready holds
// only its own register; the stages before it keep accepting until full.
module pid_position_motor_drive #(
  parameter int COUNT_WIDTH = 32,
  parameter int DUTY_WIDTH  = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // tdata: target_value, encoder_count (from bit 0 up)
  input  logic [((2*COUNT_WIDTH+7)/8)*8-1:0]      in_tdata,
  // tuser: mode
  input  logic                                    in_tuser,
  // result channel
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // tdata: forward_duty, reverse_duty, at_target (from bit 0 up)
  output logic [((2*DUTY_WIDTH+1+7)/8)*8-1:0]     out_tdata,
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [pmd_pkg::CFG_DAT_W-1:0]           cfg_data
);

  localparam int EW = COUNT_WIDTH + 1;
  localparam int DW = COUNT_WIDTH + 2;
  localparam int MX = (DUTY_WIDTH > 8) ? DUTY_WIDTH : 8;
  localparam int OW = ((2*DUTY_WIDTH+1+7)/8)*8;

  // configuration registers
  logic signed [pmd_pkg::GAIN_W-1:0]  prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [pmd_pkg::BAND_W-1:0]         dead_band_r;
  logic [pmd_pkg::LIMIT_W-1:0]        sum_limit_r;
  logic [MX-1:0]                      duty_max_r;
  logic [DUTY_WIDTH-1:0]              duty_min_r;
  logic                               enable_r;

  pmd_pkg::pmd_ctl_t                  mid_ctl;
  logic signed [EW-1:0]               mid_err;
  logic signed [pmd_pkg::ESUM_W-1:0]  mid_esum;
  logic signed [DW-1:0]               mid_diff;

  pmd_pkg::pmd_ctl_t                  mul_ctl_r, mul_ctl_nxt;
  logic                               mul_ready, mul_load, out_rdy;
  logic signed [pmd_pkg::PROD_W-1:0]  p_prop, p_integ, p_deriv;

  logic [DUTY_WIDTH-1:0]              forward_duty, reverse_duty;
  logic                               at_target;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= 16'sd256;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      dead_band_r  <= '0;
      sum_limit_r  <= 31'd65535;
      duty_max_r   <= MX'(255);
      duty_min_r   <= '0;
      enable_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (pmd_pkg::pmd_reg_t'(cfg_index))
        pmd_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_data[pmd_pkg::GAIN_W-1:0];
        pmd_pkg::REG_INTEG_GAIN: integ_gain_r <= cfg_data[pmd_pkg::GAIN_W-1:0];
        pmd_pkg::REG_DERIV_GAIN: deriv_gain_r <= cfg_data[pmd_pkg::GAIN_W-1:0];
        pmd_pkg::REG_DEAD_BAND:  dead_band_r  <= cfg_data[pmd_pkg::BAND_W-1:0];
        pmd_pkg::REG_SUM_LIMIT:  sum_limit_r  <= cfg_data[pmd_pkg::LIMIT_W-1:0];
        pmd_pkg::REG_DUTY_MAX:   duty_max_r   <= MX'(cfg_data[DUTY_WIDTH-1:0]);
        pmd_pkg::REG_DUTY_MIN:   duty_min_r   <= cfg_data[DUTY_WIDTH-1:0];
        pmd_pkg::REG_ENABLE:     enable_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // error terms and loop state
  pmd_err_stage #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_err (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_target  (in_tdata[COUNT_WIDTH-1:0]),
    .in_encoder (in_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH]),
    .enable     (enable_r),
    .dead_band  (dead_band_r),
    .sum_limit  (sum_limit_r),
    .mid_ready  (mul_ready),
    .mid_ctl    (mid_ctl),
    .mid_err    (mid_err),
    .mid_esum   (mid_esum),
    .mid_diff   (mid_diff)
  );

  // multiplier stage
  assign mul_ready = !mul_ctl_r.valid || out_rdy;
  assign mul_load  = mid_ctl.valid && mul_ready;

  always_comb begin
    mul_ctl_nxt = mul_ctl_r;
    if (mul_ctl_r.valid && out_rdy) begin
      mul_ctl_nxt.valid = 1'b0;
    end
    if (mul_load) begin
      mul_ctl_nxt = mid_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ctl_r <= '0;
    end else begin
      mul_ctl_r <= mul_ctl_nxt;
    end
  end

  pmd_sat_mul #(.XW (EW)) u_mul_prop (
    .clk (clk), .en (mul_load), .gain (prop_gain_r), .x (mid_err), .prod_r (p_prop)
  );

  pmd_sat_mul #(.XW (pmd_pkg::ESUM_W)) u_mul_integ (
    .clk (clk), .en (mul_load), .gain (integ_gain_r), .x (mid_esum), .prod_r (p_integ)
  );

  pmd_sat_mul #(.XW (DW)) u_mul_deriv (
    .clk (clk), .en (mul_load), .gain (deriv_gain_r), .x (mid_diff), .prod_r (p_deriv)
  );

  // sum, clamp and result register
  pmd_duty_stage #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_duty (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (mul_ctl_r),
    .ready        (out_rdy),
    .p_prop       (p_prop),
    .p_integ      (p_integ),
    .p_deriv      (p_deriv),
    .duty_max     (duty_max_r),
    .duty_min     (duty_min_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .forward_duty (forward_duty),
    .reverse_duty (reverse_duty),
    .at_target    (at_target)
  );

  assign out_tdata = OW'({at_target, reverse_duty, forward_duty});

  // at target always means brake
  a_at_target_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && at_target |-> (forward_duty == DUTY_WIDTH'(1)) &&
                                (reverse_duty == DUTY_WIDTH'(1)))
    else $error("at_target without brake duties");

  // never drive both bridge channels unless braking
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (forward_duty != '0) && (reverse_duty != '0) |->
      (forward_duty == DUTY_WIDTH'(1)) && (reverse_duty == DUTY_WIDTH'(1)))
    else $error("both bridge channels driven");

  // a stalled multiplier stage holds its item
  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctl_r.valid && !out_rdy |=> mul_ctl_r.valid && $stable(p_prop) &&
                                    $stable(p_integ) && $stable(p_deriv))
    else $error("multiplier stage lost a stalled item");

endmodule

/* sv/pmd_err_stage.sv */
// ----------------------------------------------------------------------------
// pmd_err_stage
// Input register, loop state, error terms; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module pmd_err_stage #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_mode,
  input  logic signed [COUNT_WIDTH-1:0]         in_target,
  input  logic signed [COUNT_WIDTH-1:0]         in_encoder,
  input  logic                                  enable,
  input  logic [pmd_pkg::BAND_W-1:0]            dead_band,
  input  logic [pmd_pkg::LIMIT_W-1:0]           sum_limit,
  input  logic                                  mid_ready,
  output pmd_pkg::pmd_ctl_t                     mid_ctl,
  output logic signed [COUNT_WIDTH:0]           mid_err,
  output logic signed [pmd_pkg::ESUM_W-1:0]     mid_esum,
  output logic signed [COUNT_WIDTH+1:0]         mid_diff
);

  localparam int EW = COUNT_WIDTH + 1;
  localparam int TW = ((EW > pmd_pkg::ESUM_W) ? EW : pmd_pkg::ESUM_W) + 1;
  localparam int DW = EW + 1;

  // input register
  logic                          in_valid_r, in_valid_nxt;
  logic                          mode_r;
  logic signed [COUNT_WIDTH-1:0] tgt_in_r;
  logic signed [COUNT_WIDTH-1:0] enc_r;

  // loop state
  logic signed [COUNT_WIDTH-1:0]        target_r, target_nxt;
  logic signed [pmd_pkg::ESUM_W-1:0]    esum_r, esum_nxt;
  logic signed [EW-1:0]                 last_r, last_nxt;
  logic                                 reached_r, reached_nxt;

  // operand register
  pmd_pkg::pmd_ctl_t                    ctl_r, ctl_nxt;
  logic signed [EW-1:0]                 err_r;
  logic signed [pmd_pkg::ESUM_W-1:0]    osum_r;
  logic signed [DW-1:0]                 diff_r;

  logic                                 slot_free, consume, is_tick, run_tick, hit;
  logic signed [EW-1:0]                 err;
  logic [EW-1:0]                        err_abs;
  logic signed [TW-1:0]                 sum_raw, lim_pos, lim_neg, sum_clamp;
  logic signed [DW-1:0]                 diff;

  // handshake
  assign slot_free = !ctl_r.valid || mid_ready;
  assign is_tick   = (mode_r == pmd_pkg::MODE_TICK);
  assign consume   = in_valid_r && (!is_tick || !enable || slot_free);
  assign run_tick  = consume && is_tick && enable;
  assign in_ready  = !in_valid_r || consume;

  // error and deadband test
  assign err     = EW'(target_r) - EW'(enc_r);
  assign err_abs = err[EW-1] ? -err : err;
  assign hit     = reached_r || (err_abs <= {{(EW-pmd_pkg::BAND_W){1'b0}}, dead_band});

  // clamped error sum and derivative term
  assign sum_raw   = TW'(esum_r) + TW'(err);
  assign lim_pos   = {{(TW-pmd_pkg::LIMIT_W){1'b0}}, sum_limit};
  assign lim_neg   = -lim_pos;
  assign sum_clamp = (sum_raw > lim_pos) ? lim_pos :
                     (sum_raw < lim_neg) ? lim_neg : sum_raw;
  assign diff      = DW'(err) - DW'(last_r);

  // next state
  always_comb begin
    in_valid_nxt = in_valid_r;
    target_nxt   = target_r;
    esum_nxt     = esum_r;
    last_nxt     = last_r;
    reached_nxt  = reached_r;
    ctl_nxt      = ctl_r;
    if (consume) begin
      in_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
    if (ctl_r.valid && mid_ready) begin
      ctl_nxt.valid = 1'b0;
    end
    if (consume && !is_tick) begin
      target_nxt  = tgt_in_r;
      esum_nxt    = '0;
      last_nxt    = '0;
      reached_nxt = 1'b0;
    end else if (run_tick) begin
      ctl_nxt.valid = 1'b1;
      ctl_nxt.brake = hit;
      if (hit) begin
        reached_nxt = 1'b1;
        esum_nxt    = '0;
        last_nxt    = '0;
      end else begin
        esum_nxt = sum_clamp[pmd_pkg::ESUM_W-1:0];
        last_nxt = err;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      target_r   <= '0;
      esum_r     <= '0;
      last_r     <= '0;
      reached_r  <= 1'b0;
      ctl_r      <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      target_r   <= target_nxt;
      esum_r     <= esum_nxt;
      last_r     <= last_nxt;
      reached_r  <= reached_nxt;
      ctl_r      <= ctl_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      tgt_in_r <= in_target;
      enc_r    <= in_encoder;
    end
    if (run_tick) begin
      err_r  <= err;
      osum_r <= sum_clamp[pmd_pkg::ESUM_W-1:0];
      diff_r <= diff;
    end
  end

  assign mid_ctl  = ctl_r;
  assign mid_err  = err_r;
  assign mid_esum = osum_r;
  assign mid_diff = diff_r;

  // reached always leaves the loop state cleared
  a_reached_clear: assert property (@(posedge clk) disable iff (!rst_n)
    reached_r |-> (esum_r == '0) && (last_r == '0))
    else $error("loop state not cleared while reached");

endmodule

/* sv/pmd_sat_mul.sv */
// ----------------------------------------------------------------------------
// pmd_sat_mul
// Gain times operand with saturation at +-2^60, registered product.
// ----------------------------------------------------------------------------
module pmd_sat_mul #(
  parameter int XW = 33
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [pmd_pkg::GAIN_W-1:0]   gain,
  input  logic signed [XW-1:0]                x,
  output logic signed [pmd_pkg::PROD_W-1:0]   prod_r
);

  // operand kept one bit wider than the bound so that +2^45 still fits
  localparam int MW = (XW < pmd_pkg::SAT_X_W + 1) ? XW : pmd_pkg::SAT_X_W + 1;
  localparam int BW = (XW > pmd_pkg::SAT_X_W + 1) ? XW : pmd_pkg::SAT_X_W + 1;
  localparam logic signed [BW-1:0] BOUND = BW'(pmd_pkg::SAT_BOUND);

  logic signed [BW-1:0]                    x_ext;
  logic signed [MW-1:0]                    x_m;
  logic signed [pmd_pkg::GAIN_W+MW-1:0]    prod;
  logic                                    over;
  logic signed [pmd_pkg::PROD_W-1:0]       prod_nxt;

  // operand range check, then a narrow multiply
  assign x_ext = BW'(x);
  assign over  = (x_ext > BOUND) || (x_ext < -BOUND);
  assign x_m   = x[MW-1:0];
  assign prod  = gain * x_m;

  always_comb begin
    if (gain == '0 || x == '0) begin
      prod_nxt = '0;
    end else if (over) begin
      prod_nxt = (gain[pmd_pkg::GAIN_W-1] == x[XW-1]) ? pmd_pkg::PROD_LIM
                                                      : -pmd_pkg::PROD_LIM;
    end else begin
      prod_nxt = pmd_pkg::PROD_W'(prod);
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* sv/pmd_duty_stage.sv */
// ----------------------------------------------------------------------------
// pmd_duty_stage
// PID sum, truncation, duty clamp and lift, forward/reverse split.
// ----------------------------------------------------------------------------
module pmd_duty_stage #(
  parameter int DUTY_WIDTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pmd_pkg::pmd_ctl_t                   ctl,
  output logic                                ready,
  input  logic signed [pmd_pkg::PROD_W-1:0]   p_prop,
  input  logic signed [pmd_pkg::PROD_W-1:0]   p_integ,
  input  logic signed [pmd_pkg::PROD_W-1:0]   p_deriv,
  input  logic [((DUTY_WIDTH > 8) ? DUTY_WIDTH : 8)-1:0] duty_max,
  input  logic [DUTY_WIDTH-1:0]               duty_min,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [DUTY_WIDTH-1:0]               forward_duty,
  output logic [DUTY_WIDTH-1:0]               reverse_duty,
  output logic                                at_target
);

  localparam int MX = (DUTY_WIDTH > 8) ? DUTY_WIDTH : 8;
  localparam int AW = pmd_pkg::ACC_W;
  localparam int SW = AW - 1 - pmd_pkg::FRAC_W;

  logic                          valid_r, valid_nxt;
  logic [DUTY_WIDTH-1:0]         fwd_r, rev_r;
  logic                          at_r;
  logic [DUTY_WIDTH-1:0]         fwd_nxt, rev_nxt;
  logic                          at_nxt;

  logic signed [AW-1:0]          acc;
  logic [AW-2:0]                 acc_mag;
  logic [SW-1:0]                 shifted;
  logic [MX-1:0]                 mag, lifted;
  logic                          load;

  assign ready = !valid_r || out_ready;
  assign load  = ctl.valid && ready;

  // sum and magnitude truncated toward zero
  assign acc     = AW'(p_prop) + AW'(p_integ) + AW'(p_deriv);
  assign acc_mag = acc[AW-1] ? (AW-1)'(-acc) : (AW-1)'(acc);
  assign shifted = acc_mag[AW-2:pmd_pkg::FRAC_W];
  assign mag     = (shifted > SW'(duty_max)) ? duty_max : shifted[MX-1:0];
  assign lifted  = (mag < MX'(duty_min)) ? MX'(duty_min) : mag;

  // result selection
  always_comb begin
    at_nxt  = 1'b0;
    fwd_nxt = DUTY_WIDTH'(1);
    rev_nxt = DUTY_WIDTH'(1);
    if (ctl.brake) begin
      at_nxt = 1'b1;
    end else if (mag != '0) begin
      if (acc[AW-1]) begin
        fwd_nxt = '0;
        rev_nxt = lifted[DUTY_WIDTH-1:0];
      end else begin
        fwd_nxt = lifted[DUTY_WIDTH-1:0];
        rev_nxt = '0;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fwd_r <= fwd_nxt;
      rev_r <= rev_nxt;
      at_r  <= at_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign forward_duty = fwd_r;
  assign reverse_duty = rev_r;
  assign at_target    = at_r;

endmodule

/* test/pid_position_motor_drive_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_position_motor_drive_test
// Self-checking bench for the PID position motor drive controller. Set-target
// and tick items stream in with bursts and gaps while the result side stalls
// on its own pattern. A predictor of the control loop runs on every accepted
// item and each duty result is compared field by field, in order.
// ----------------------------------------------------------------------------
module pid_position_motor_drive_test;

  localparam int     STALL_LIMIT   = 3000;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     FRAC_BITS     = 8;
  localparam longint MUL_BOUND     = 64'sd1 <<< 45;
  localparam longint PROD_CAP      = 64'sd1 <<< 60;

  typedef struct {
    logic        mode;
    logic [31:0] target;
    logic [31:0] enc;
  } drive_item_t;

  typedef struct packed {
    logic       at;
    logic [7:0] rev;
    logic [7:0] fwd;
  } duty_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  drive_item_t drive_q[$];
  duty_res_t   duty_expect_q[$];
  drive_item_t cur_item;
  bit          in_taken = 1'b0;
  int          fail_cnt = 0;
  int          idle_cycles = 0;

  // sender and receiver pacing
  bit tx_gaps = 1'b1;
  int burst_left = 0;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_phase = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;

  // predictor copy of the registers, reset values
  longint kp_r = 256;
  longint ki_r = 0;
  longint kd_r = 0;
  longint band_r = 0;
  longint limit_r = 65535;
  longint dmax_r = 255;
  longint dmin_r = 0;
  bit     enable_r = 1'b1;

  // predictor copy of the loop state
  longint tgt_pos = 0;
  longint err_sum = 0;
  longint prev_err = 0;
  bit     at_goal = 1'b0;

  pid_position_motor_drive u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // gain times operand, saturating like the block's multipliers
  function automatic longint scaled(longint gain, longint x);
    if (gain == 0 || x == 0)
      scaled = 0;
    else if (x > MUL_BOUND || x < -MUL_BOUND)
      scaled = ((gain > 0) == (x > 0)) ? PROD_CAP : -PROD_CAP;
    else
      scaled = gain * x;
  endfunction

  // one control step: updates the loop state, returns the duty if any
  task automatic predict_drive(input drive_item_t it, output bit has_res,
                               output duty_res_t res);
    longint err, acc, mag;
    has_res = 1'b0;
    res = '0;
    if (it.mode == pmd_pkg::MODE_SET_TARGET) begin
      tgt_pos = longint'($signed(it.target));
      err_sum = 0;
      prev_err = 0;
      at_goal = 1'b0;
    end else if (enable_r) begin
      has_res = 1'b1;
      err = tgt_pos - longint'($signed(it.enc));
      if (at_goal || ((err < 0) ? -err : err) <= band_r) begin
        // target reached: latch and brake
        at_goal = 1'b1;
        err_sum = 0;
        prev_err = 0;
        res.at = 1'b1;
        res.rev = 8'd1;
        res.fwd = 8'd1;
      end else begin
        err_sum = err_sum + err;
        if (err_sum > limit_r) err_sum = limit_r;
        if (err_sum < -limit_r) err_sum = -limit_r;
        acc = scaled(kp_r, err) + scaled(ki_r, err_sum) + scaled(kd_r, err - prev_err);
        prev_err = err;
        mag = ((acc < 0) ? -acc : acc) >>> FRAC_BITS;
        if (mag > dmax_r) mag = dmax_r;
        if (mag == 0) begin
          // request truncates to zero: brake without at_target
          res.rev = 8'd1;
          res.fwd = 8'd1;
        end else begin
          if (mag < dmin_r) mag = dmin_r;
          if (acc > 0) res.fwd = mag[7:0];
          else res.rev = mag[7:0];
        end
      end
    end
  endtask

  // acceptance, prediction, result check and watchdog
  always @(posedge clk) begin
    duty_res_t exp_r;
    duty_res_t got_r;
    bit        has_res;
    bit        out_fire;
    bit        cfg_fire;
    if (rst_n) begin
      in_taken = in_tvalid && in_tready;
      out_fire = out_tvalid && out_tready;
      cfg_fire = cfg_valid && cfg_ready;
      if (cfg_fire) begin
        case (pmd_pkg::pmd_reg_t'(cfg_index))
          pmd_pkg::REG_PROP_GAIN:  kp_r = longint'($signed(cfg_data[15:0]));
          pmd_pkg::REG_INTEG_GAIN: ki_r = longint'($signed(cfg_data[15:0]));
          pmd_pkg::REG_DERIV_GAIN: kd_r = longint'($signed(cfg_data[15:0]));
          pmd_pkg::REG_DEAD_BAND:  band_r = longint'(cfg_data[15:0]);
          pmd_pkg::REG_SUM_LIMIT:  limit_r = longint'(cfg_data[30:0]);
          pmd_pkg::REG_DUTY_MAX:   dmax_r = longint'(cfg_data[7:0]);
          pmd_pkg::REG_DUTY_MIN:   dmin_r = longint'(cfg_data[7:0]);
          pmd_pkg::REG_ENABLE:     enable_r = cfg_data[0];
          default: ;
        endcase
      end
      if (in_taken) begin
        predict_drive(cur_item, has_res, exp_r);
        if (has_res) duty_expect_q.push_back(exp_r);
      end
      if (out_fire) begin
        got_r = out_tdata[16:0];
        if (duty_expect_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, actual fwd %0d rev %0d at %0b",
                   $time, got_r.fwd, got_r.rev, got_r.at);
        end else begin
          exp_r = duty_expect_q.pop_front();
          if (got_r.fwd !== exp_r.fwd) begin
            fail_cnt++;
            $display("%0t: forward_duty expected %0d actual %0d", $time, exp_r.fwd, got_r.fwd);
          end
          if (got_r.rev !== exp_r.rev) begin
            fail_cnt++;
            $display("%0t: reverse_duty expected %0d actual %0d", $time, exp_r.rev, got_r.rev);
          end
          if (got_r.at !== exp_r.at) begin
            fail_cnt++;
            $display("%0t: at_target expected %0b actual %0b", $time, exp_r.at, got_r.at);
          end
        end
      end
      // watchdog on cycles with no handshake at all
      if (in_taken || out_fire || cfg_fire)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, duty_expect_q.size());
        $display("[pid_position_motor_drive] ERROR");
        $finish;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // sender: bursts of items with gaps, holds an item until it is taken
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (drive_q.size() != 0) begin
        cur_item = drive_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_item.mode;
        in_tdata <= {cur_item.enc, cur_item.target};
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 && tx_gaps) begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern per phase, plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 9) < 3);
        default: begin
          rx_phase = (rx_phase + 1) % 7;
          out_tready <= (rx_phase < 4);
        end
      endcase
    end
  end

  task automatic write_reg(input pmd_pkg::pmd_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
                       input logic [31:0] band, input logic [31:0] lim,
                       input logic [31:0] dmax, input logic [31:0] dmin,
                       input logic [31:0] en);
    write_reg(pmd_pkg::REG_PROP_GAIN, kp);
    write_reg(pmd_pkg::REG_INTEG_GAIN, ki);
    write_reg(pmd_pkg::REG_DERIV_GAIN, kd);
    write_reg(pmd_pkg::REG_DEAD_BAND, band);
    write_reg(pmd_pkg::REG_SUM_LIMIT, lim);
    write_reg(pmd_pkg::REG_DUTY_MAX, dmax);
    write_reg(pmd_pkg::REG_DUTY_MIN, dmin);
    write_reg(pmd_pkg::REG_ENABLE, en);
  endtask

  // unused field of each item carries random bits
  task automatic add_target(input logic [31:0] t);
    drive_item_t it;
    it.mode = pmd_pkg::MODE_SET_TARGET;
    it.target = t;
    it.enc = $urandom;
    drive_q.push_back(it);
  endtask

  task automatic add_tick(input logic [31:0] e);
    drive_item_t it;
    it.mode = pmd_pkg::MODE_TICK;
    it.target = $urandom;
    it.enc = e;
    drive_q.push_back(it);
  endtask

  // wait until every item is in and every result out, then let the pipe empty
  task automatic drain();
    while (drive_q.size() != 0 || in_tvalid || duty_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: pick_gain = 32'h0000_7fff;
      1: pick_gain = 32'hffff_8000;
      2: pick_gain = 32'd0;
      3: pick_gain = $urandom;
      default: pick_gain = $urandom_range(0, 1024) - 512;
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] band, lim, dmax, dmin;
    case ($urandom_range(0, 4))
      0: band = 32'd0;
      1: band = 32'd65535;
      2: band = $urandom_range(0, 300);
      default: band = $urandom_range(0, 20);
    endcase
    case ($urandom_range(0, 4))
      0: lim = 32'd0;
      1: lim = 32'h7fff_ffff;
      2: lim = $urandom;
      default: lim = $urandom_range(0, 5000);
    endcase
    case ($urandom_range(0, 5))
      0: dmax = 32'd255;
      1: dmax = $urandom_range(0, 255);
      2: dmax = 32'd0;
      default: dmax = $urandom_range(100, 255);
    endcase
    case ($urandom_range(0, 5))
      0: dmin = 32'd0;
      1: dmin = 32'd255;
      2: dmin = $urandom_range(0, 255);
      default: dmin = $urandom_range(0, 40);
    endcase
    setup(pick_gain(), pick_gain(), ($urandom_range(0, 1) ? pick_gain() : 32'd0),
          band, lim, dmax, dmin, 32'd1);
  endtask

  // mostly target-then-ticks runs around the target, some raw noise
  task automatic add_runs(input int count);
    drive_item_t it;
    logic [31:0] t, d;
    int pushed, n;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 8) begin
        t = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000;
        add_target(t);
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 7))
            0: d = $urandom;
            1: d = $urandom_range(0, 200000) - 100000;
            2, 3: d = $urandom_range(0, 30) - 15;
            default: d = $urandom_range(0, 2000) - 1000;
          endcase
          add_tick(t - d);
        end
        pushed += n + 1;
      end else begin
        it.mode = 1'($urandom_range(0, 1));
        it.target = $urandom;
        it.enc = $urandom;
        drive_q.push_back(it);
        pushed++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: reached at zero target, both directions, count extremes
    add_tick(32'd0);
    add_tick(32'd5);
    add_target(32'd100);
    add_tick(32'd0);
    add_tick(32'd200);
    add_tick(32'd99);
    add_target(32'h7fff_ffff);
    add_tick(32'h8000_0000);
    add_target(32'h8000_0000);
    add_tick(32'h7fff_ffff);
    add_target(-5);
    add_tick(-5);
    drain();

    // zero request, duty_min above duty_max, deadband entry
    setup(32'd1, 32'd0, 32'd0, 32'd5, 32'd65535, 32'd20, 32'd50, 32'd1);
    add_target(32'd1000);
    add_tick(32'd900);
    add_tick(32'd0);
    add_tick(32'd2000);
    add_tick(32'd1003);
    add_tick(32'd0);
    drain();

    // gain extremes with zero sum limit
    setup(32'hffff_8000, 32'h0000_7fff, 32'hffff_8000, 32'd0, 32'd0, 32'd255, 32'd0, 32'd1);
    add_target(32'd10);
    add_tick(32'd0);
    add_tick(32'd20);
    add_tick(32'd10);
    drain();

    // widest deadband, widest sum limit, zero duty_max
    setup(32'd0, 32'h0000_7fff, 32'h0000_7fff, 32'd65535, 32'h7fff_ffff, 32'd0, 32'd255,
          32'd1);
    add_target(32'd0);
    add_tick(32'd100000);
    add_tick(-100000);
    add_tick(32'd65535);
    drain();

    // disabled: ticks ignored, set-target still taken
    setup(32'd256, 32'd0, 32'd0, 32'd0, 32'd65535, 32'd255, 32'd0, 32'd0);
    add_tick(32'd7);
    add_target(32'd50);
    add_tick(32'd50);
    drain();
    write_reg(pmd_pkg::REG_ENABLE, 32'd1);
    add_tick(32'd0);
    drain();

    // random phases with varied pacing, one with a long result hold-off
    for (int ph = 0; ph < 10; ph++) begin
      random_setup();
      rx_mode = ph % 4;
      tx_gaps = (ph % 3 != 0);
      if (ph == 5) begin
        rx_mode = 0;
        tx_gaps = 1'b0;
        hold_req++;
      end
      add_runs(150);
      drain();
    end

    if (fail_cnt == 0)
      $display("[pid_position_motor_drive] OK");
    else
      $display("[pid_position_motor_drive] ERROR");
    $finish;
  end

endmodule
